/* hw/rtl/swik_pkg.sv */
package swik_pkg;

  localparam int SincosStagesDefault = 16;
  localparam int AtanEntries = 24;
  localparam int AngW = 34;
  localparam int CordW = 34;

  localparam logic signed [AngW-1:0] GainQ30 = 34'sd652032874;
  localparam logic signed [AngW-1:0] PiQ30 = 34'sd3373259426;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;

  localparam logic [1:0] RegInvWheelRadius = 2'd0;
  localparam logic [1:0] RegHalfTrack = 2'd1;
  localparam logic [1:0] RegInvCasterOffset = 2'd2;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic signed [AngW-1:0] z;
    logic flip;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_yaw;
    logic valid;
  } cord_t;

  function automatic logic signed [AngW-1:0] atan_q30(input int i);
    logic signed [AngW-1:0] r;
    begin
      case (i)
        0: r = 34'sd843314857;
        1: r = 34'sd497837829;
        2: r = 34'sd263043837;
        3: r = 34'sd133525159;
        4: r = 34'sd67021687;
        5: r = 34'sd33543516;
        6: r = 34'sd16775851;
        7: r = 34'sd8388437;
        8: r = 34'sd4194283;
        9: r = 34'sd2097149;
        default: r = (i < AtanEntries) ? (34'sd1 <<< (30 - i)) : 34'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

/* hw/rtl/steered_wheel_inverse_kinematics_unit.sv */
// Fully pipelined: one command accepted per clock (busy is always low), result
// strobed by done after the input register, the row of SINCOS_STAGES CORDIC cells
// (stage count capped at 24) and the velocity-rotation and coefficient multiplier
// stages. Results must be sampled in the done cycle; they are not held.
module steered_wheel_inverse_kinematics_unit #(
  parameter int SINCOS_STAGES = swik_pkg::SincosStagesDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] joint_angle,
  input  logic signed [31:0] vel_x,
  input  logic signed [31:0] vel_y,
  input  logic signed [31:0] vel_yaw,
  output logic done,
  output logic signed [31:0] right_wheel_rate,
  output logic signed [31:0] left_wheel_rate,
  output logic signed [31:0] steer_rate,
  output logic saturated,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [3:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  localparam int N = (SINCOS_STAGES > swik_pkg::AtanEntries) ?
                     swik_pkg::AtanEntries : SINCOS_STAGES;
  localparam int Latency = N + 6;

  logic [31:0] coef_a, coef_b, coef_c;
  logic wr;
  assign pready = 1'b1;
  assign busy = 1'b0;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a <= 32'd65536;
      coef_b <= 32'd65536;
      coef_c <= 32'd65536;
    end else if (wr) begin
      case (paddr[3:2])
        swik_pkg::RegInvWheelRadius: coef_a <= pwdata;
        swik_pkg::RegHalfTrack: coef_b <= pwdata;
        swik_pkg::RegInvCasterOffset: coef_c <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      swik_pkg::RegInvWheelRadius: prdata = coef_a;
      swik_pkg::RegHalfTrack: prdata = coef_b;
      swik_pkg::RegInvCasterOffset: prdata = coef_c;
      default: prdata = '0;
    endcase
  end

  swik_pkg::cord_t head, head_q;
  swik_pkg::cord_t chain [0:N];
  logic signed [swik_pkg::AngW-1:0] z0;

  always_comb begin
    z0 = swik_pkg::AngW'(joint_angle) <<< 17;
    head.x = swik_pkg::GainQ30;
    head.y = '0;
    head.flip = 1'b0;
    head.z = z0;
    if (z0 > swik_pkg::HalfPiQ30) begin
      head.z = z0 - swik_pkg::PiQ30;
      head.flip = 1'b1;
    end else if (z0 < -swik_pkg::HalfPiQ30) begin
      head.z = z0 + swik_pkg::PiQ30;
      head.flip = 1'b1;
    end
    head.vel_x = vel_x;
    head.vel_y = vel_y;
    head.vel_yaw = vel_yaw;
    head.valid = start & ~busy & ~rst;
  end

  always_ff @(posedge clk) begin
    head_q <= head;
  end

  assign chain[0] = head_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    swik_cordic_cell #(.Index(i)) u_cell (
      .clk(clk), .rst(rst), .din(chain[i]), .dout(chain[i+1])
    );
  end

  swik_back_end u_back (
    .clk(clk), .rst(rst), .din(chain[N]),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .done(done),
    .right_wheel_rate(right_wheel_rate),
    .left_wheel_rate(left_wheel_rate),
    .steer_rate(steer_rate),
    .saturated(saturated)
  );

`ifndef SYNTHESIS
  a_busy_low: assert property (@(posedge clk) !busy) else $error("busy high");
  a_no_done_after_reset: assert property (@(posedge clk) $past(rst) |-> !chain[0].valid)
    else $error("valid after reset");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##Latency done)
    else $error("result missing after a command transfer");
`endif

endmodule

/* hw/rtl/swik_cordic_cell.sv */
module swik_cordic_cell #(
  parameter int Index = 0
) (
  input  logic clk,
  input  logic rst,
  input  swik_pkg::cord_t din,
  output swik_pkg::cord_t dout
);

  swik_pkg::cord_t nxt;

  always_comb begin
    nxt = din;
    nxt.valid = din.valid & ~rst;
    if (din.z >= 0) begin
      nxt.x = din.x - (din.y >>> Index);
      nxt.y = din.y + (din.x >>> Index);
      nxt.z = din.z - swik_pkg::atan_q30(Index);
    end else begin
      nxt.x = din.x + (din.y >>> Index);
      nxt.y = din.y - (din.x >>> Index);
      nxt.z = din.z + swik_pkg::atan_q30(Index);
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

/* hw/rtl/swik_back_end.sv */
module swik_back_end (
  input  logic clk,
  input  logic rst,
  input  swik_pkg::cord_t din,
  input  logic [31:0] coef_a,
  input  logic [31:0] coef_b,
  input  logic [31:0] coef_c,
  output logic done,
  output logic signed [31:0] right_wheel_rate,
  output logic signed [31:0] left_wheel_rate,
  output logic signed [31:0] steer_rate,
  output logic saturated
);

  localparam int CW = swik_pkg::CordW;

  // stage 1: four products of sin/cos with velocities
  logic signed [65:0] cx, sy, cy, sx;
  logic signed [31:0] yaw1, yaw2, yaw3, yaw4;
  logic v1, v2, v3, v4, v5;
  logic signed [CW-1:0] c0, s0;

  always_comb begin
    c0 = din.flip ? -din.x : din.x;
    s0 = din.flip ? -din.y : din.y;
  end

  always_ff @(posedge clk) begin
    cx <= 66'(c0) * 66'(din.vel_x);
    sy <= 66'(s0) * 66'(din.vel_y);
    cy <= 66'(c0) * 66'(din.vel_y);
    sx <= 66'(s0) * 66'(din.vel_x);
    yaw1 <= din.vel_yaw;
  end

  // stage 2: rotate into caster frame
  logic signed [35:0] u, w;
  logic signed [66:0] su, sw;
  always_comb begin
    su = 67'(cx) + 67'(sy) + 67'sd536870912;
    sw = 67'(cy) - 67'(sx) + 67'sd536870912;
  end
  always_ff @(posedge clk) begin
    u <= 36'(su >>> 30);
    w <= 36'(sw >>> 30);
    yaw2 <= yaw1;
  end

  // stage 3: coefficient partial products
  logic signed [53:0] ahi, bhi, chi, alo, blo, clo;
  always_ff @(posedge clk) begin
    ahi <= 54'($signed({1'b0, coef_a[31:16]})) * 54'(u);
    bhi <= 54'($signed({1'b0, coef_b[31:16]})) * 54'(w);
    chi <= 54'($signed({1'b0, coef_c[31:16]})) * 54'(w);
    alo <= 54'($signed({1'b0, coef_a[15:0]})) * 54'(u);
    blo <= 54'($signed({1'b0, coef_b[15:0]})) * 54'(w);
    clo <= 54'($signed({1'b0, coef_c[15:0]})) * 54'(w);
    yaw3 <= yaw2;
  end

  // stage 4: round low parts and combine
  logic signed [54:0] au, bw, cw;
  always_ff @(posedge clk) begin
    au <= 55'(ahi) + 55'((alo + 54'sd32768) >>> 16);
    bw <= 55'(bhi) + 55'((blo + 54'sd32768) >>> 16);
    cw <= 55'(chi) + 55'((clo + 54'sd32768) >>> 16);
    yaw4 <= yaw3;
  end

  // stage 5: sums and clipping
  logic signed [55:0] r, l, st;
  logic sr, sl, ss;
  logic signed [31:0] rq, lq, sq;
  localparam logic signed [55:0] Max = 56'sd2147483647;
  localparam logic signed [55:0] Min = -56'sd2147483648;
  always_comb begin
    r = 56'(au) + 56'(bw);
    l = 56'(au) - 56'(bw);
    st = 56'(cw) - 56'(yaw4);
    sr = (r > Max) || (r < Min);
    sl = (l > Max) || (l < Min);
    ss = (st > Max) || (st < Min);
    rq = (r > Max) ? 32'sh7fffffff : (r < Min) ? 32'sh80000000 : r[31:0];
    lq = (l > Max) ? 32'sh7fffffff : (l < Min) ? 32'sh80000000 : l[31:0];
    sq = (st > Max) ? 32'sh7fffffff : (st < Min) ? 32'sh80000000 : st[31:0];
  end
  always_ff @(posedge clk) begin
    right_wheel_rate <= rq;
    left_wheel_rate <= lq;
    steer_rate <= sq;
    saturated <= sr | sl | ss;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= din.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  assign done = v5;

endmodule

/* tb/steered_wheel_inverse_kinematics_unit_tb.sv */
module steered_wheel_inverse_kinematics_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Stages = swik_pkg::SincosStagesDefault;
  localparam int Latency = Stages + 6;
  localparam int CycleLimit = 400000;
  localparam logic [1:0] RegUnused = 2'd3;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;
  localparam logic signed [15:0] PiQ13 = 16'sd25736;
  localparam logic signed [31:0] VelMax = 32'sh7fffffff;
  localparam logic signed [31:0] VelMin = 32'sh80000000;

  localparam longint AtanTable [24] = '{
    843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437,
    4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048,
    1024, 512, 256, 128
  };

  typedef struct packed {
    logic signed [31:0] right;
    logic signed [31:0] left;
    logic signed [31:0] steer;
    logic sat;
  } wheel_rates_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] joint_angle = '0;
  logic signed [31:0] vel_x = '0;
  logic signed [31:0] vel_y = '0;
  logic signed [31:0] vel_yaw = '0;
  logic done;
  logic signed [31:0] right_wheel_rate;
  logic signed [31:0] left_wheel_rate;
  logic signed [31:0] steer_rate;
  logic saturated;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [31:0] coef_wheel = 32'd65536;
  logic [31:0] coef_track = 32'd65536;
  logic [31:0] coef_caster = 32'd65536;

  wheel_rates_t expected_rates[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  steered_wheel_inverse_kinematics_unit dut (.*);

  always #5 clk = ~clk;

  // round-half-up of coef * v / 2^16, split to keep within 64 bits
  function automatic longint scale_by_coef(logic [31:0] k, longint v);
    longint hi;
    longint lo;
    hi = k[31:16];
    lo = k[15:0];
    return hi * v + ((lo * v + 32768) >>> 16);
  endfunction

  function automatic logic signed [31:0] clip_rate(longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return VelMax;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return VelMin;
    end
    return v[31:0];
  endfunction

  function automatic wheel_rates_t predict_wheel_rates(logic signed [15:0] ang,
      logic signed [31:0] vx, logic signed [31:0] vy, logic signed [31:0] vyaw);
    longint z, x, y, dx, dy, s, c, u, w, au, bw, cw;
    logic flip;
    int n;
    wheel_rates_t r;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    n = (Stages > 24) ? 24 : Stages;
    // fold into the cordic's convergence range
    if (z > 64'sd1686629713) begin
      z = z - 64'sd3373259426;
      flip = 1'b1;
    end else if (z < -64'sd1686629713) begin
      z = z + 64'sd3373259426;
      flip = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - AtanTable[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + AtanTable[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    u = (c * longint'(vx) + s * longint'(vy) + 536870912) >>> 30;
    w = (c * longint'(vy) - s * longint'(vx) + 536870912) >>> 30;
    au = scale_by_coef(coef_wheel, u);
    bw = scale_by_coef(coef_track, w);
    cw = scale_by_coef(coef_caster, w);
    r.sat = 1'b0;
    r.right = clip_rate(au + bw, r.sat);
    r.left = clip_rate(au - bw, r.sat);
    r.steer = clip_rate(cw - longint'(vyaw), r.sat);
    return r;
  endfunction

  // result checker and run limit
  always @(posedge clk) begin
    wheel_rates_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[steered_wheel_inverse_kinematics_unit] ERROR");
      $finish;
    end else if (!rst && done) begin
      if (expected_rates.size() == 0) begin
        $error("result with no pending command");
        errors++;
      end else begin
        e = expected_rates.pop_front();
        if (right_wheel_rate !== e.right) begin
          $error("right_wheel_rate exp %0d got %0d", e.right, right_wheel_rate);
          errors++;
        end
        if (left_wheel_rate !== e.left) begin
          $error("left_wheel_rate exp %0d got %0d", e.left, left_wheel_rate);
          errors++;
        end
        if (steer_rate !== e.steer) begin
          $error("steer_rate exp %0d got %0d", e.steer, steer_rate);
          errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated exp %0b got %0b", e.sat, saturated);
          errors++;
        end
      end
    end
  end

  task automatic send_command(logic signed [15:0] ang, logic signed [31:0] vx,
      logic signed [31:0] vy, logic signed [31:0] vyaw);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    joint_angle <= ang;
    vel_x <= vx;
    vel_y <= vy;
    vel_yaw <= vyaw;
    forever begin
      @(negedge clk);
      if (!busy) begin
        @(posedge clk);
        break;
      end
      @(posedge clk);
    end
    expected_rates.push_back(predict_wheel_rates(ang, vx, vy, vyaw));
  endtask

  // stop sending and wait for every outstanding transfer to come back
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (expected_rates.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      swik_pkg::RegInvWheelRadius: coef_wheel = value;
      swik_pkg::RegHalfTrack: coef_track = value;
      swik_pkg::RegInvCasterOffset: coef_caster = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata !== value) begin
      $error("prdata reg %0d exp %0h got %0h", idx, value, prdata);
      errors++;
    end
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    write_reg(swik_pkg::RegInvWheelRadius, a);
    write_reg(swik_pkg::RegHalfTrack, b);
    write_reg(swik_pkg::RegInvCasterOffset, c);
    check_reg(swik_pkg::RegInvWheelRadius, a);
    check_reg(swik_pkg::RegHalfTrack, b);
    check_reg(swik_pkg::RegInvCasterOffset, c);
  endtask

  function automatic logic signed [31:0] rand_vel();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
      2: return $signed($urandom_range(0, 1 << 27)) - (1 << 26);
      default: return $urandom_range(1) ? VelMax - $urandom_range(3) : VelMin + $urandom_range(3);
    endcase
  endfunction

  function automatic logic signed [15:0] rand_angle();
    if ($urandom_range(3) == 0) return 16'($urandom_range(0, 65535));
    return 16'($signed($urandom_range(0, 2 * PiQ13)) - PiQ13);
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(1, 32'h0004_0000);
      2: return 32'hffff_ffff;
      default: return $urandom_range(32'h0000_4000, 32'h0010_0000);
    endcase
  endfunction

  task automatic test_directed;
    logic signed [15:0] angles [10];
    angles = '{16'sd0, PiQ13, -PiQ13, 16'sd32767, -16'sd32768,
               HalfPiQ13, -HalfPiQ13, 16'(HalfPiQ13 + 1), 16'(-HalfPiQ13 - 1), 16'sd6434};
    foreach (angles[i]) send_command(angles[i], 32'sd65536, -32'sd131072, 32'sd98304);
    send_command(16'sd0, VelMax, VelMax, VelMin);
    send_command(16'sd0, VelMin, VelMin, VelMax);
    send_command(PiQ13, VelMin, VelMax, VelMax);
    send_command(-16'sd32768, VelMax, VelMin, 32'sd0);
    send_command(16'sd3217, 32'sd0, 32'sd0, 32'sd0);
    drain();
    // largest coefficients drive rates into clipping
    set_coefs(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_command(16'sd100, VelMax, VelMax, VelMin);
    send_command(-16'sd9000, VelMin, VelMax, VelMax);
    send_command(16'sd0, 32'sd65536, 32'sd65536, 32'sd0);
    drain();
    // zero coefficient gives zero terms
    set_coefs(32'd0, 32'd0, 32'd0);
    send_command(16'sd5000, VelMax, VelMin, VelMin);
    send_command(-16'sd20000, 32'sd12345, -32'sd6789, 32'sd4242);
    drain();
    set_coefs(32'd1, 32'd1, 32'd1);
    send_command(16'sd1000, VelMax, VelMin, 32'sd7);
    drain();
    // writes beyond the last register are dropped
    write_reg(RegUnused, 32'hdead_beef);
    check_reg(swik_pkg::RegInvWheelRadius, coef_wheel);
    send_command(16'sd1000, 32'sd5000000, 32'sd70000, 32'sd1);
  endtask

  task automatic test_random_phase(int pct, int n_items);
    idle_pct = pct;
    for (int k = 0; k < n_items; k++) begin
      if (k % 150 == 0) begin
        drain();
        case ((k / 150) % 3)
          0: set_coefs(rand_coef(), rand_coef(), rand_coef());
          1: set_coefs(32'd1, 32'hffff_ffff, 32'd65536);
          default: set_coefs($urandom, $urandom, $urandom);
        endcase
      end else if ($urandom_range(99) == 0) begin
        drain();
      end
      send_command(rand_angle(), rand_vel(), rand_vel(), rand_vel());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(6, 450);
    test_random_phase(72, 450);
    test_random_phase(0, 450);
    drain();
    if (errors == 0) begin
      $display("[steered_wheel_inverse_kinematics_unit] OK");
    end else begin
      $display("[steered_wheel_inverse_kinematics_unit] ERROR");
    end
    $finish;
  end

endmodule
